FILE: rtl/caeu_pkg.sv
`timescale 1ns / 1ps
package caeu_pkg;

    localparam int FRAME_LENGTH = 1600;
    localparam int HALF_LENGTH  = FRAME_LENGTH / 2;
    localparam int MAX_TICKS    = 16;

    localparam int CODE_W     = 8;
    localparam int SAMPLE_W   = 16;
    localparam int IN_RATE_W  = 17;
    localparam int OUT_RATE_W = 18;
    localparam int PHASE_W    = 19;
    localparam int SUM_W      = PHASE_W + 1;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = OUT_RATE_W;

    localparam int TICK_W = $clog2(MAX_TICKS);
    // output index must be able to hold FRAME_LENGTH itself (frame full)
    localparam int OIDX_W = $clog2(FRAME_LENGTH + 1);
    // fade index runs below HALF_LENGTH
    localparam int HIDX_W = ($clog2(HALF_LENGTH) > 0) ? $clog2(HALF_LENGTH) : 1;

    localparam logic [PHASE_W-1:0]    PHASE_MAX     = {PHASE_W{1'b1}};
    localparam logic [IN_RATE_W-1:0]  IN_RATE_RST   = IN_RATE_W'(24000);
    localparam logic [OUT_RATE_W-1:0] OUT_RATE_RST  = OUT_RATE_W'(48000);

    localparam logic [CFG_IDX_W-1:0] CFG_IN_RATE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_RATE = CFG_IDX_W'(1);

    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       fade;
        logic [HIDX_W-1:0]          fidx;
        logic                       last_of_code;
        logic                       last_of_frame;
    } tick_out_t;

    // segment/step expansion; negative codes are the complement of the magnitude
    function automatic logic signed [SAMPLE_W-1:0] expand_code(input logic [CODE_W-1:0] code);
        logic [2:0]          seg;
        logic [3:0]          step;
        logic [SAMPLE_W-1:0] mag;
        seg  = code[6:4];
        step = code[3:0];
        if (seg == 3'd0) begin
            mag = {8'd0, step, 4'd0};
        end else begin
            mag = {11'd0, 1'b1, step} << ({1'b0, seg} + 4'd3);
        end
        return code[7] ? ~mag : mag;
    endfunction

endpackage

FILE: rtl/companded_audio_expand_upsample_top.sv
`timescale 1ns / 1ps
// Path from code request to first output sample: tick, scale multiply and divide stages.
// Throughput: one output sample per cycle while codes keep coming and m_ready does not stall;
// a code gives the floor or ceil of out_rate/in_rate samples as the phase falls (1 to 16, two
// at the reset rates), fewer when the frame fills, and a code arriving on a full frame gives none.
// Reset (aresetn, synchronous, active low): rates back to 24000/48000, accumulator, held
// sample, frame index and fade cleared, pipeline emptied; s_ready high from the first reset edge.
module companded_audio_expand_upsample_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [caeu_pkg::CODE_W-1:0]          s_code,
    input  logic                                 s_first_of_frame,
    input  logic                                 s_fade_in,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [caeu_pkg::SAMPLE_W-1:0] m_sample,
    output logic                                 m_last_of_code,
    output logic                                 m_last_of_frame,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [caeu_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [caeu_pkg::CFG_DATA_W-1:0]      cfg_data
);

    caeu_pkg::tick_out_t tick;
    logic                pipe_adv;

    caeu_tick u_tick (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_code           (s_code),
        .s_first_of_frame (s_first_of_frame),
        .s_fade_in        (s_fade_in),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .pipe_adv         (pipe_adv),
        .tick             (tick)
    );

    caeu_fade u_fade (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .tick            (tick),
        .pipe_adv        (pipe_adv),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sample        (m_sample),
        .m_last_of_code  (m_last_of_code),
        .m_last_of_frame (m_last_of_frame)
    );

endmodule

FILE: rtl/caeu_tick.sv
`timescale 1ns / 1ps
module caeu_tick (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [caeu_pkg::CODE_W-1:0]        s_code,
    input  logic                               s_first_of_frame,
    input  logic                               s_fade_in,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [caeu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [caeu_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               pipe_adv,
    output caeu_pkg::tick_out_t                tick
);

    logic [caeu_pkg::IN_RATE_W-1:0]  in_rate_reg;
    logic [caeu_pkg::OUT_RATE_W-1:0] out_rate_reg;

    logic                               busy_reg, busy_next;
    logic [caeu_pkg::CODE_W-1:0]        code_reg, code_next;
    logic [caeu_pkg::TICK_W-1:0]        cnt_reg, cnt_next;
    logic [caeu_pkg::PHASE_W-1:0]       phase_reg, phase_next;
    logic signed [caeu_pkg::SAMPLE_W-1:0] held_reg, held_next;
    logic [caeu_pkg::OIDX_W-1:0]        idx_reg, idx_next;
    logic                               fade_reg, fade_next;

    logic [caeu_pkg::SUM_W-1:0]         sum, sum_adj;
    logic [caeu_pkg::PHASE_W-1:0]       phase_tick;
    logic signed [caeu_pkg::SAMPLE_W-1:0] decoded, emit;
    logic take, full, last_idx, fire, retire, accept;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_rate_reg  <= caeu_pkg::IN_RATE_RST;
            out_rate_reg <= caeu_pkg::OUT_RATE_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                caeu_pkg::CFG_IN_RATE:  in_rate_reg  <= cfg_data[caeu_pkg::IN_RATE_W-1:0];
                caeu_pkg::CFG_OUT_RATE: out_rate_reg <= cfg_data[caeu_pkg::OUT_RATE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        decoded = caeu_pkg::expand_code(code_reg);
        sum     = {1'b0, phase_reg} + caeu_pkg::SUM_W'(in_rate_reg);
        sum_adj = sum;
        take    = 1'b0;
        if (sum >= caeu_pkg::SUM_W'(out_rate_reg)) begin
            sum_adj = sum - caeu_pkg::SUM_W'(out_rate_reg);
            take    = 1'b1;
        end else if (cnt_reg == caeu_pkg::TICK_W'(caeu_pkg::MAX_TICKS - 1)) begin
            // ratio too high: force the take on the last allowed tick
            sum_adj = '0;
            take    = 1'b1;
        end
        phase_tick = (sum_adj > caeu_pkg::SUM_W'(caeu_pkg::PHASE_MAX)) ?
                     caeu_pkg::PHASE_MAX : sum_adj[caeu_pkg::PHASE_W-1:0];

        full     = idx_reg >= caeu_pkg::OIDX_W'(caeu_pkg::FRAME_LENGTH);
        last_idx = idx_reg == caeu_pkg::OIDX_W'(caeu_pkg::FRAME_LENGTH - 1);
        fire     = busy_reg && pipe_adv && !full;
        retire   = busy_reg && pipe_adv && (full || take || last_idx);
        s_ready  = !busy_reg || retire;
        accept   = s_valid && s_ready;
        emit     = take ? decoded : held_reg;

        busy_next  = busy_reg;
        code_next  = code_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        held_next  = held_reg;
        idx_next   = idx_reg;
        fade_next  = fade_reg;

        if (fire) begin
            phase_next = phase_tick;
            held_next  = emit;
            idx_next   = idx_reg + 1'b1;
            cnt_next   = cnt_reg + 1'b1;
        end
        if (retire) begin
            busy_next = 1'b0;
        end
        if (accept) begin
            busy_next = 1'b1;
            code_next = s_code;
            cnt_next  = '0;
            if (s_first_of_frame) begin
                phase_next = '0;
                held_next  = '0;
                idx_next   = '0;
                fade_next  = s_fade_in;
            end
        end

        tick.valid         = fire;
        tick.sample        = emit;
        tick.fade          = fade_reg && (idx_reg < caeu_pkg::OIDX_W'(caeu_pkg::HALF_LENGTH));
        tick.fidx          = idx_reg[caeu_pkg::HIDX_W-1:0];
        tick.last_of_code  = take;
        tick.last_of_frame = last_idx;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
            phase_reg <= '0;
            held_reg  <= '0;
            idx_reg   <= '0;
            fade_reg  <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
            held_reg  <= held_next;
            idx_reg   <= idx_next;
            fade_reg  <= fade_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg <= code_next;
    end

endmodule

FILE: rtl/caeu_fade.sv
`timescale 1ns / 1ps
module caeu_fade (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  caeu_pkg::tick_out_t                  tick,
    output logic                                 pipe_adv,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [caeu_pkg::SAMPLE_W-1:0] m_sample,
    output logic                                 m_last_of_code,
    output logic                                 m_last_of_frame
);

    // floor(p / HALF_LENGTH) as (p * RECIP) >> SHIFT, exact for p below 2**P_W
    localparam int P_W     = caeu_pkg::SAMPLE_W + caeu_pkg::HIDX_W;
    localparam int SHIFT   = P_W + $clog2(caeu_pkg::HALF_LENGTH);
    localparam int RECIP_W = P_W + 2;
    localparam int PROD_W  = P_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(caeu_pkg::HALF_LENGTH) - 64'd1) / 64'(caeu_pkg::HALF_LENGTH);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    caeu_pkg::tick_out_t r1_reg;

    logic                                 r2_valid_reg;
    logic [P_W-1:0]                       r2_prod_reg, r2_prod_next;
    logic                                 r2_neg_reg;
    logic                                 r2_fade_reg;
    logic signed [caeu_pkg::SAMPLE_W-1:0] r2_sample_reg;
    logic                                 r2_loc_reg;
    logic                                 r2_lof_reg;

    logic                                 out_valid_reg;
    logic signed [caeu_pkg::SAMPLE_W-1:0] out_sample_reg, out_sample_next;
    logic                                 out_loc_reg;
    logic                                 out_lof_reg;

    logic [caeu_pkg::SAMPLE_W-1:0] mag;
    logic [PROD_W-1:0]             scaled;
    logic [caeu_pkg::SAMPLE_W-1:0] quot;

    assign pipe_adv = !out_valid_reg || m_ready;

    always_comb begin
        // truncation toward zero: scale the magnitude, restore the sign after
        mag = r1_reg.sample[caeu_pkg::SAMPLE_W-1] ?
              caeu_pkg::SAMPLE_W'(-r1_reg.sample) : caeu_pkg::SAMPLE_W'(r1_reg.sample);
        r2_prod_next = P_W'(mag) * P_W'(r1_reg.fidx);

        scaled = PROD_W'(r2_prod_reg) * PROD_W'(RECIP);
        quot   = scaled[SHIFT +: caeu_pkg::SAMPLE_W];
        if (!r2_fade_reg) begin
            out_sample_next = r2_sample_reg;
        end else if (r2_neg_reg) begin
            out_sample_next = -$signed(quot);
        end else begin
            out_sample_next = $signed(quot);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r1_reg.valid  <= 1'b0;
            r2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (pipe_adv) begin
            r1_reg.valid  <= tick.valid;
            r2_valid_reg  <= r1_reg.valid;
            out_valid_reg <= r2_valid_reg;
        end

        if (pipe_adv) begin
            r1_reg.sample        <= tick.sample;
            r1_reg.fade          <= tick.fade;
            r1_reg.fidx          <= tick.fidx;
            r1_reg.last_of_code  <= tick.last_of_code;
            r1_reg.last_of_frame <= tick.last_of_frame;

            r2_prod_reg   <= r2_prod_next;
            r2_neg_reg    <= r1_reg.sample[caeu_pkg::SAMPLE_W-1];
            r2_fade_reg   <= r1_reg.fade;
            r2_sample_reg <= r1_reg.sample;
            r2_loc_reg    <= r1_reg.last_of_code;
            r2_lof_reg    <= r1_reg.last_of_frame;

            out_sample_reg <= out_sample_next;
            out_loc_reg    <= r2_loc_reg;
            out_lof_reg    <= r2_lof_reg;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_sample        = out_sample_reg;
    assign m_last_of_code  = out_loc_reg;
    assign m_last_of_frame = out_lof_reg;

endmodule

FILE: rtl/caeu_checker.sv
`timescale 1ns / 1ps
module caeu_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_ready,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic signed [caeu_pkg::SAMPLE_W-1:0] m_sample,
    input logic                                 m_last_of_frame
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sample))
        else $error("stalled output request changed");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid straight after reset");

    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready straight after reset");

    // a frame end that is taken is never directly followed by another valid frame end
    a_frame_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_of_frame |=> !(m_valid && m_last_of_frame))
        else $error("two frame ends back to back");

endmodule

bind companded_audio_expand_upsample_top caeu_checker u_checker (.*);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import caeu_pkg::*;

    localparam int QUIET_LIMIT = 3000;  // cycles with no transfer of any kind
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE_WAIT = 8;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_of_code;
        logic                       last_of_frame;
    } pcm_result_t;

    class pcm_scoreboard;
        logic [IN_RATE_W-1:0]       in_rate;
        logic [OUT_RATE_W-1:0]      out_rate;
        logic [PHASE_W-1:0]         phase_sum;
        logic signed [SAMPLE_W-1:0] held;
        int                         out_idx;
        bit                         fade_on;
        pcm_result_t                want_q[$];
        int                         errors;
        int                         matched;

        function new();
            in_rate   = IN_RATE_RST;
            out_rate  = OUT_RATE_RST;
            phase_sum = '0;
            held      = '0;
            out_idx   = 0;
            fade_on   = 1'b0;
            errors    = 0;
            matched   = 0;
        endfunction

        function void set_rate(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
            if (idx == CFG_IN_RATE) begin
                in_rate = IN_RATE_W'(val);
            end else if (idx == CFG_OUT_RATE) begin
                out_rate = OUT_RATE_W'(val);
            end
        endfunction

        function int pending();
            return want_q.size();
        endfunction

        function bit frame_full();
            return out_idx >= FRAME_LENGTH;
        endfunction

        function logic signed [SAMPLE_W-1:0] decode_byte(input logic [CODE_W-1:0] c);
            int seg;
            int stp;
            int mag;
            seg = c[6:4];
            stp = c[3:0];
            if (seg == 0) begin
                mag = stp * 16;
            end else begin
                mag = (256 << (seg - 1)) + (16 << (seg - 1)) * stp;
            end
            // negative codes are the one's complement of the magnitude
            return c[7] ? SAMPLE_W'(-mag - 1) : SAMPLE_W'(mag);
        endfunction

        function logic signed [SAMPLE_W-1:0] faded(input logic signed [SAMPLE_W-1:0] v,
                                                   input int idx);
            int scaled;
            if (fade_on && idx < HALF_LENGTH) begin
                scaled = (int'(v) * idx) / HALF_LENGTH;  // truncates toward zero
                return SAMPLE_W'(scaled);
            end
            return v;
        endfunction

        function void note_code(input logic [CODE_W-1:0] c, input bit first, input bit fade);
            int                 n;
            int                 idx;
            bit                 take;
            logic [SUM_W-1:0]   acc;
            pcm_result_t        r;
            if (first) begin
                phase_sum = '0;
                held      = '0;
                out_idx   = 0;
                fade_on   = fade;
            end
            n    = 0;
            take = 1'b0;
            while (!take && out_idx < FRAME_LENGTH && n < MAX_TICKS) begin
                acc = SUM_W'(phase_sum) + SUM_W'(in_rate);
                idx = out_idx;
                if (acc >= SUM_W'(out_rate)) begin
                    acc  = acc - SUM_W'(out_rate);
                    take = 1'b1;
                end else if (n == MAX_TICKS - 1) begin
                    // ratio too high: take on the last tick anyway
                    acc  = '0;
                    take = 1'b1;
                end
                phase_sum = (acc > SUM_W'(PHASE_MAX)) ? PHASE_MAX : acc[PHASE_W-1:0];
                if (take) begin
                    held = decode_byte(c);
                end
                r.sample        = faded(held, idx);
                r.last_of_code  = take;
                r.last_of_frame = (idx == FRAME_LENGTH - 1);
                want_q.push_back(r);
                n++;
                out_idx = idx + 1;
            end
        endfunction

        function void check(input logic signed [SAMPLE_W-1:0] sample,
                            input logic lc, input logic lf);
            pcm_result_t w;
            if (want_q.size() == 0) begin
                $display("%0t: unexpected sample %0d (last_of_code %b, last_of_frame %b)",
                         $time, sample, lc, lf);
                errors++;
                return;
            end
            w = want_q.pop_front();
            matched++;
            if (sample !== w.sample) begin
                $display("%0t: sample mismatch, expected %0d, actual %0d",
                         $time, w.sample, sample);
                errors++;
            end
            if (lc !== w.last_of_code) begin
                $display("%0t: last_of_code mismatch, expected %b, actual %b",
                         $time, w.last_of_code, lc);
                errors++;
            end
            if (lf !== w.last_of_frame) begin
                $display("%0t: last_of_frame mismatch, expected %b, actual %b",
                         $time, w.last_of_frame, lf);
                errors++;
            end
        endfunction
    endclass

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic [CODE_W-1:0]          s_code;
    logic                       s_first_of_frame;
    logic                       s_fade_in;
    logic                       m_valid;
    logic                       m_ready;
    logic signed [SAMPLE_W-1:0] m_sample;
    logic                       m_last_of_code;
    logic                       m_last_of_frame;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    pcm_scoreboard sb = new();
    bit            src_calm;
    bit            sink_calm;
    int            quiet_cycles;

    // each entry is {fade_in, first_of_frame, code}
    localparam logic [9:0] DIRECTED [20] = '{
        10'h000, 10'h0FF, 10'h07F, 10'h080, 10'h00F, 10'h010, 10'h08F, 10'h090,
        10'h055, 10'h0AA, 10'h070, 10'h0F0,
        10'h37F, 10'h0FF, 10'h040, 10'h0C0,
        10'h133, 10'h0CC, 10'h221, 10'h001
    };

    companded_audio_expand_upsample_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_code           (s_code),
        .s_first_of_frame (s_first_of_frame),
        .s_fade_in        (s_fade_in),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_sample         (m_sample),
        .m_last_of_code   (m_last_of_code),
        .m_last_of_frame  (m_last_of_frame),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // valid is left high on return so the next request can follow without a gap
    task automatic send_code(input logic [CODE_W-1:0] c, input logic first, input logic fade);
        int gap;
        if ($urandom_range(0, 39) == 0) begin
            src_calm = !src_calm;
        end
        gap = pick_gap(src_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_code           <= c;
        s_first_of_frame <= first;
        s_fade_in        <= fade;
        do @(posedge aclk); while (!s_ready);
        sb.note_code(c, first, fade);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        do @(posedge aclk); while (!cfg_ready);
        sb.set_rate(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // stop offering codes and wait out every outstanding sample
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);
    endtask

    task automatic run_phase(input int unsigned ir, input int unsigned orr, input int items,
                             input bit fill_frame);
        int   k;
        logic first;
        logic fade;
        settle();
        write_reg(CFG_IN_RATE, ir);
        write_reg(CFG_OUT_RATE, orr);
        k = 0;
        while (k < items || (fill_frame && !sb.frame_full())) begin
            first = (k == 0) || (!fill_frame && $urandom_range(0, 29) == 0);
            fade  = (fill_frame && k == 0) ? 1'b1 : 1'($urandom_range(0, 1));
            send_code(CODE_W'($urandom_range(0, 255)), first, fade);
            k++;
        end
        // a full frame drops codes until the next frame start
        if (fill_frame) begin
            repeat (4) send_code(CODE_W'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check(m_sample, m_last_of_code, m_last_of_frame);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    // sample sink: random back-pressure plus one long hold while codes keep coming
    initial begin
        int  hold;
        bit  held_once;
        m_ready   = 1'b0;
        held_once = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if ($urandom_range(0, 49) == 0) begin
                sink_calm = !sink_calm;
            end
            if (!held_once && sb.matched >= 60) begin
                held_once = 1'b1;
                hold      = LONG_HOLD;
            end else begin
                hold = pick_gap(sink_calm);
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    initial begin
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_code           = '0;
        s_first_of_frame = 1'b0;
        s_fade_in        = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        src_calm         = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset rates; until the first frame start in the list, codes act as an unfaded frame
        foreach (DIRECTED[i]) begin
            send_code(DIRECTED[i][7:0], DIRECTED[i][8], DIRECTED[i][9]);
        end

        run_phase(5000, 79000, 6, 1'b1);     // fills a frame, ends mid-code
        run_phase(1000, 192000, 8, 1'b0);    // ratio too high, forced take
        run_phase(96000, 8000, 8, 1'b0);     // ratio below one, accumulator saturates
        run_phase(0, 48000, 3, 1'b0);
        run_phase(131071, 0, 4, 1'b0);
        run_phase(96000, 192000, 10, 1'b0);
        run_phase(1000, 8000, 6, 1'b0);
        run_phase(100000, 262143, 6, 1'b0);
        run_phase(24000, 48000, 8, 1'b0);

        settle();
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/caeu_pkg.sv
rtl/caeu_tick.sv
rtl/caeu_fade.sv
rtl/companded_audio_expand_upsample_top.sv
rtl/caeu_checker.sv
tb/testbench.sv
